[hw/rtl/bot_pkg.sv]
// ----------------------------------------------------------------------------
// bot_pkg
// Types, constants and the overlap test shared by the box table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bot_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned SlotW             = 6;
  localparam int unsigned TagW              = 16;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_w;
    logic        [14:0] box_h;
    logic        [15:0] object_tag;
  } bot_req_t;

  typedef struct packed {
    logic             hit;
    logic [TagW-1:0]  hit_tag;
    logic [SlotW-1:0] hit_slot;
    logic             store_dropped;
  } bot_res_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
  } bot_box_t;

  typedef struct packed {
    logic             valid;
    bot_box_t         box;
    logic [TagW-1:0]  tag;
    logic             found;
    logic [SlotW-1:0] slot;
    logic [TagW-1:0]  hit_tag;
  } bot_token_t;

  localparam logic KindQuery = 1'b0;
  localparam logic KindClear = 1'b1;

  function automatic logic bot_overlap(input bot_box_t s, input bot_box_t q);
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [16:0] qx;
    logic signed [16:0] qy;
    logic signed [16:0] sxw;
    logic signed [16:0] syh;
    logic signed [16:0] qxw;
    logic signed [16:0] qyh;
    sx  = {s.x[15], s.x};
    sy  = {s.y[15], s.y};
    qx  = {q.x[15], q.x};
    qy  = {q.y[15], q.y};
    sxw = sx + $signed({2'b00, s.w});
    syh = sy + $signed({2'b00, s.h});
    qxw = qx + $signed({2'b00, q.w});
    qyh = qy + $signed({2'b00, q.h});
    return (sx < qxw) && (qx < sxw) && (sy < qyh) && (qy < syh);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/box_overlap_table_top.sv]
// ----------------------------------------------------------------------------
// box_overlap_table_top
// Box table with strict overlap search over a chain of per-slot cells.
// ----------------------------------------------------------------------------
// Query request: result strobe registered from the end of the cell chain; the
// request walks the chain one slot per cycle, so one query at a time.
// Clear request: result strobe in the cycle after acceptance.
// busy is low again in the cycle of the strobe; results cannot be stalled.
// Reset empties the table; stored boxes need no clearing pass.
`default_nettype none

module box_overlap_table_top import bot_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bot_req_t req_i,
  output logic          done_o,
  output bot_res_t      res_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  bot_token_t      tok [0:TableDepth];
  bot_token_t      head;
  logic [CntW-1:0] count_q, count_d;
  logic            pass_q, pass_d;
  logic            done_q;
  bot_res_t        res_q, res_d;
  logic            accept;
  logic            full;
  bot_token_t      tail;

  assign accept = start && !busy;
  assign full   = count_q == CntW'(TableDepth);
  assign tail   = tok[TableDepth];

  always_comb begin
    head.valid   = accept && (req_i.kind == KindQuery);
    head.box.x   = req_i.box_x;
    head.box.y   = req_i.box_y;
    head.box.w   = req_i.box_w;
    head.box.h   = req_i.box_h;
    head.tag     = req_i.object_tag;
    head.found   = 1'b0;
    head.slot    = '0;
    head.hit_tag = '0;
  end

  assign tok[0] = head;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    bot_cell #(
      .TableDepth(TableDepth),
      .Index     (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .count_i(count_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    pass_d  = pass_q;
    res_d   = res_q;
    if (accept && (req_i.kind == KindClear)) begin
      count_d = '0;
      res_d   = '0;
    end else if (accept) begin
      pass_d = 1'b1;
    end
    if (tail.valid) begin
      pass_d              = 1'b0;
      res_d.hit           = tail.found;
      res_d.hit_tag       = tail.hit_tag;
      res_d.hit_slot      = tail.slot;
      res_d.store_dropped = full;
      if (!full) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pass_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pass_q  <= pass_d;
      done_q  <= tail.valid || (accept && (req_i.kind == KindClear));
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy   = pass_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_tail_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> pass_q)
    else $error("request left the chain outside a pass");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.kind == KindQuery)) |=> busy)
    else $error("query accepted without raising busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.store_dropped) |-> full)
    else $error("drop flagged with free slots");

endmodule

`default_nettype wire

[hw/rtl/bot_cell.sv]
// ----------------------------------------------------------------------------
// bot_cell
// One table slot: holds a box and its tag, tests the passing request and stores it when first free.
// ----------------------------------------------------------------------------
`default_nettype none

module bot_cell import bot_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned Index      = 0,
  localparam int unsigned CntW      = $clog2(TableDepth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CntW-1:0] count_i,
  input  wire bot_token_t      tok_i,
  output bot_token_t           tok_o
);

  bot_box_t        box_q;
  logic [TagW-1:0] tag_q;
  bot_token_t      tok_d;
  bot_token_t      tok_q;
  logic            in_use;

  assign in_use = CntW'(Index) < count_i;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && in_use && bot_overlap(box_q, tok_i.box)) begin
      tok_d.found   = 1'b1;
      tok_d.slot    = SlotW'(Index);
      tok_d.hit_tag = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    // append into the first free slot
    if (tok_i.valid && (count_i == CntW'(Index))) begin
      box_q <= tok_i.box;
      tag_q <= tok_i.tag;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
